// ===== src/dpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfc_pkg
// Shared constants for the distinct prime factor counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfc_pkg;

    // width of the value and factor_count ports
    localparam int VALUE_WIDTH  = 20;
    localparam int COUNT_WIDTH  = 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 3'd7;

    // table covers every value below 2^VALUE_BITS
    localparam int VALUE_BITS   = 20;
    localparam int TABLE_SIZE   = 1 << VALUE_BITS;

    // a marked entry holds a factor no larger than the square root
    localparam int FACTOR_BITS  = (VALUE_BITS + 1) / 2;
    localparam int SQ_BITS      = 2 * FACTOR_BITS;

    // sieve index, one bit above the table range to flag the end of a row
    localparam int SIEVE_BITS   = VALUE_BITS + 1;

    // value port zero-extended past the table width before masking
    localparam int EXT_BITS     = VALUE_BITS + VALUE_WIDTH;

    // divider step counter
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

endpackage

`default_nettype wire

// ===== src/distinct_prime_factor_count.sv =====
// ----------------------------------------------------------------------------
// distinct_prime_factor_count
// Counts the distinct prime factors of a value using a smallest-factor table.
// ----------------------------------------------------------------------------
// After reset the block builds a smallest-prime-factor table in an on-chip
// memory of 2^VALUE_BITS entries and holds in_stall high until it is done:
// first a clearing pass over every entry, then the sieve, one table write a
// cycle while it marks a row. Each accepted word is then factored by table
// lookup and exact division; the divider takes one quotient bit a cycle. A
// query divides out one table factor per lookup; the last, prime, factor
// needs no division. One query is worked on at a time; the result sits in an
// output register, so the next word is taken while the previous result waits
// for the sink. factor_count saturates at 7.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_prime_factor_count
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dpfc_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [dpfc_pkg::COUNT_WIDTH-1:0] factor_count
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_SQUARE,
        S_MARK,
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // sieve counters
    logic [dpfc_pkg::VALUE_BITS-1:0]  clr_reg,   clr_next;
    logic [dpfc_pkg::FACTOR_BITS-1:0] i_reg,     i_next;
    logic [dpfc_pkg::SIEVE_BITS-1:0]  j_reg,     j_next;

    // query
    logic [dpfc_pkg::VALUE_BITS-1:0]  n_reg,     n_next;
    logic [dpfc_pkg::VALUE_BITS-1:0]  last_reg,  last_next;
    logic [dpfc_pkg::COUNT_WIDTH-1:0] count_reg, count_next;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic [dpfc_pkg::COUNT_WIDTH-1:0] result_reg,    result_next;

    // smallest-factor table, 0 = prime (or below 2)
    logic [dpfc_pkg::FACTOR_BITS-1:0] sf_mem [dpfc_pkg::TABLE_SIZE];
    logic [dpfc_pkg::FACTOR_BITS-1:0] rdata_reg;
    logic                             mem_we;
    logic [dpfc_pkg::VALUE_BITS-1:0]  mem_waddr;
    logic [dpfc_pkg::FACTOR_BITS-1:0] mem_wdata;

    logic [dpfc_pkg::EXT_BITS-1:0]    value_ext;
    logic [dpfc_pkg::SQ_BITS-1:0]     square;
    logic [dpfc_pkg::VALUE_BITS-1:0]  factor;
    logic                             in_acc;
    logic                             out_free;

    logic                             div_start;
    logic                             div_done;
    logic [dpfc_pkg::VALUE_BITS-1:0]  div_quotient;

    assign value_ext = dpfc_pkg::EXT_BITS'(value);
    assign square    = dpfc_pkg::SQ_BITS'(i_reg) * dpfc_pkg::SQ_BITS'(i_reg);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // unmarked entry: the remaining value is itself prime
    assign factor = (rdata_reg == '0) ? n_reg : dpfc_pkg::VALUE_BITS'(rdata_reg);

    // sieve runs from the top factor down with blind writes; the last write
    // to an entry is its smallest divisor i with i*i <= entry, which is its
    // smallest prime factor
    assign mem_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_MARK && !j_reg[dpfc_pkg::VALUE_BITS]);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : j_reg[dpfc_pkg::VALUE_BITS-1:0];
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : i_reg;

    assign div_start = (state_reg == S_EVAL) && (rdata_reg != '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sf_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= sf_mem[n_reg];
    end

    dpfc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (factor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    i_next     = '1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                j_next     = dpfc_pkg::SIEVE_BITS'(square);
                state_next = S_MARK;
            end
            S_MARK:
            begin
                if (j_reg[dpfc_pkg::VALUE_BITS])
                begin
                    if (i_reg == dpfc_pkg::FACTOR_BITS'(2))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_SQUARE;
                    end
                end
                else
                begin
                    j_next = j_reg + dpfc_pkg::SIEVE_BITS'(i_reg);
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    n_next     = value_ext[dpfc_pkg::VALUE_BITS-1:0];
                    last_next  = '0;
                    count_next = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // table read of n issues this cycle
                if (n_reg <= dpfc_pkg::VALUE_BITS'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (factor != last_reg)
                begin
                    last_next = factor;
                    if (count_reg != dpfc_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                if (rdata_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    n_next     = div_quotient;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign factor_count = result_reg;

endmodule

`default_nettype wire

// ===== src/dpfc_div.sv =====
// ----------------------------------------------------------------------------
// dpfc_div
// Restoring divider, one quotient bit per cycle; done flags the finished
// quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfc_div
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [dpfc_pkg::VALUE_BITS-1:0] dividend,
    input  wire logic [dpfc_pkg::VALUE_BITS-1:0] divisor,
    output logic                                 done,
    output logic      [dpfc_pkg::VALUE_BITS-1:0] quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [dpfc_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [dpfc_pkg::VALUE_BITS-1:0]   quo_reg;
    logic [dpfc_pkg::VALUE_BITS-1:0]   rem_reg;
    logic [dpfc_pkg::VALUE_BITS-1:0]   dvs_reg;

    logic [dpfc_pkg::VALUE_BITS:0]     shifted;
    logic [dpfc_pkg::VALUE_BITS+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[dpfc_pkg::VALUE_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // borrow clear: divisor fits, take the bit
                if (!diff[dpfc_pkg::VALUE_BITS+1])
                begin
                    rem_reg <= diff[dpfc_pkg::VALUE_BITS-1:0];
                    quo_reg <= {quo_reg[dpfc_pkg::VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[dpfc_pkg::VALUE_BITS-1:0];
                    quo_reg <= {quo_reg[dpfc_pkg::VALUE_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == dpfc_pkg::DIV_CNT_BITS'(dpfc_pkg::VALUE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/dpfc_checker.sv =====
// ----------------------------------------------------------------------------
// dpfc_checker
// Port-level checks for the distinct prime factor counter.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfc_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [dpfc_pkg::COUNT_WIDTH-1:0] factor_count
);

    // words taken but not yet delivered
    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(factor_count))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result with no word outstanding");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> in_stall)
        else $error("input taken with two words outstanding");

    a_sieve_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("block active before table is built");

endmodule

bind distinct_prime_factor_count dpfc_checker u_dpfc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .factor_count (factor_count)
);

`default_nettype wire

// ===== bench/tb_distinct_prime_factor_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_prime_factor_count
// Self-checking bench for the distinct prime factor counter.
// ----------------------------------------------------------------------------
// The bench builds its own smallest-factor table at time zero and predicts
// the count for every word taken on the input. Each result taken on the
// output is compared with the oldest prediction. Stimulus starts with a
// directed set: edge values, primes beyond the square root of the table,
// prime squares, long chains of twos and saturating products. After that
// come random words, half of them smooth numbers that keep the divider busy.
// The sender idles in bursts and the receiver stalls on its own pattern.
// Once, the receiver holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------

module tb_distinct_prime_factor_count;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1330;
    // idle time after the last result, with margin over the longest query
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLDOFF_AT   = 300;
    localparam int HOLDOFF_LEN  = 1500;
    // watchdog limit: clearing pass plus sieve, allowed several times over
    localparam longint LIMIT_CYCLES = 40 * longint'(dpfc_pkg::TABLE_SIZE) + 2_000_000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic [dpfc_pkg::VALUE_WIDTH-1:0] value     = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [dpfc_pkg::COUNT_WIDTH-1:0] factor_count;

    distinct_prime_factor_count i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .factor_count (factor_count)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own smallest-factor table, 0 = prime or below 2
    // ------------------------------------------------------------------------
    bit [dpfc_pkg::FACTOR_BITS-1:0] smallest_prime [dpfc_pkg::TABLE_SIZE];

    logic [dpfc_pkg::VALUE_WIDTH-1:0] pending_values [$];
    logic [dpfc_pkg::COUNT_WIDTH-1:0] expected_counts [$];

    int error_count    = 0;
    int words_accepted = 0;
    bit in_taken       = 1'b0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    stall_mode_t stall_mode   = STALL_NONE;
    int          mode_left    = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    function automatic void build_factor_table();
        longint i;
        longint j;
        for (i = 0; i < dpfc_pkg::TABLE_SIZE; i++)
            smallest_prime[i] = '0;
        for (i = 2; i * i < dpfc_pkg::TABLE_SIZE; i++)
        begin
            if (smallest_prime[i] == 0)
            begin
                for (j = i * i; j < dpfc_pkg::TABLE_SIZE; j += i)
                begin
                    if (smallest_prime[j] == 0)
                        smallest_prime[j] = dpfc_pkg::FACTOR_BITS'(i);
                end
            end
        end
    endfunction

    // factor by lookup and division; unmarked entry above 1 means n is prime
    function automatic logic [dpfc_pkg::COUNT_WIDTH-1:0] distinct_primes(
        logic [dpfc_pkg::VALUE_WIDTH-1:0] v);
        longint n;
        longint p;
        longint last;
        int     count;
        n     = longint'(v) & longint'(dpfc_pkg::TABLE_SIZE - 1);
        last  = 0;
        count = 0;
        while (n > 1)
        begin
            p = smallest_prime[n];
            if (p == 0)
                p = n;
            if (p != last)
            begin
                if (count < int'(dpfc_pkg::COUNT_MAX))
                    count++;
                last = p;
            end
            n = n / p;
        end
        return dpfc_pkg::COUNT_WIDTH'(count);
    endfunction

    // append a word to the stimulus queue
    function automatic void queue_value(logic [dpfc_pkg::VALUE_WIDTH-1:0] v);
        pending_values = {pending_values, v};
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset: reset held low from time zero, released on a falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: offers words from the pending queue in bursts with gaps.
    // A word is held until taken, and the decision never looks at in_stall.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_values.size() > 0)
            begin
                value    <= pending_values.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    // some bursts run straight into the next one
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes mode every so often; one long hold-off
    // once enough words have gone in, while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (!holdoff_done && words_accepted >= HOLDOFF_AT)
        begin
            out_stall    <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(10, 150);
            end
            else
                mode_left <= mode_left - 1;

            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall <= ~out_stall;
                default:      out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every word taken in, checks every word taken out
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_counts = {expected_counts, distinct_primes(value)};
                words_accepted <= words_accepted + 1;
            end

            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch($sformatf("factor_count %0d with nothing expected",
                                              factor_count));
                else
                begin
                    logic [dpfc_pkg::COUNT_WIDTH-1:0] want;
                    want = expected_counts.pop_front();
                    if (factor_count !== want)
                        report_mismatch($sformatf("factor_count %0d, expected %0d",
                                                  factor_count, want));
                end
            end
        end
        else
            in_taken <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned small_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19,
                                           23, 29, 31, 37, 41, 43, 47, 53};
        longint      top;
        longint      prod;
        longint      p;
        int          kind;

        build_factor_table();
        top = longint'(1) << dpfc_pkg::VALUE_WIDTH;

        // directed: edges, big primes left unmarked by the sieve, prime
        // squares, long runs of twos, and products that hit the saturation
        queue_value(20'd0);
        queue_value(20'd1);
        queue_value(20'd2);
        queue_value(20'd3);
        queue_value(20'd4);
        queue_value(20'hFFFFF);
        queue_value(20'h80000);
        queue_value(20'd1048573);   // largest prime below 2^20
        queue_value(20'd1031);      // prime just above sqrt
        queue_value(20'd1042441);   // 1021 squared
        queue_value(20'd1022117);   // 1009 * 1013
        queue_value(20'd510510);    // seven smallest primes
        queue_value(20'd1021020);   // same, with 2 squared
        queue_value(20'd870870);
        queue_value(20'd881790);
        queue_value(20'd746130);
        queue_value(20'd531441);    // 3^12
        queue_value(20'd30030);
        queue_value(20'hAAAAA);
        queue_value(20'h55555);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
                // uniform over the whole field
                queue_value(dpfc_pkg::VALUE_WIDTH'($urandom_range(0, top - 1)));
            else if (kind == 3)
                queue_value(dpfc_pkg::VALUE_WIDTH'($urandom_range(0, 255)));
            else if (kind == 4)
            begin
                // prime power
                p    = small_primes[$urandom_range(0, 15)];
                prod = p;
                while (prod * p < top && $urandom_range(0, 7) != 0)
                    prod = prod * p;
                queue_value(dpfc_pkg::VALUE_WIDTH'(prod));
            end
            else
            begin
                // smooth number: many factors, long division chains
                prod = 1;
                do
                begin
                    p = small_primes[$urandom_range(0, 15)];
                    if (prod * p < top)
                        prod = prod * p;
                end
                while ($urandom_range(0, 9) != 0 && prod * 2 < top);
                // sometimes tack on a large cofactor to reach the high bits
                if ($urandom_range(0, 2) == 0 && prod < top / 2)
                    prod = prod * $urandom_range(1, (top - 1) / prod);
                queue_value(dpfc_pkg::VALUE_WIDTH'(prod));
            end
        end

        @(posedge rst_n);
        while (pending_values.size() != 0 || in_valid || expected_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_counts.size() == 0)
            $display("distinct_prime_factor_count test passed");
        else
            $display("distinct_prime_factor_count test failed");
        $finish;
    end

    // watchdog: covers the clearing pass and sieve after reset several times
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("distinct_prime_factor_count test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/dpfc_pkg.sv
src/dpfc_div.sv
src/distinct_prime_factor_count.sv
src/dpfc_checker.sv
bench/tb_distinct_prime_factor_count.sv
